>>> rtl/edp_pkg.sv
`default_nettype none

package edp_pkg;

    // Fixed field widths
    localparam int GAIN_W      = 16;
    localparam int DUTY_W      = 8;
    localparam int BASE_W      = 8;
    localparam int CMD_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_CNT_W   = 16;
    localparam int INTEGRAL_W  = 24;

    // Gain reset values, Q8.8
    localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd591;
    localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = 16'd243;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    typedef enum logic [CMD_W-1:0] {
        CMD_PULSE = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_FWD   = 3'd2,
        CMD_BWD   = 3'd3,
        CMD_STOP  = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P = 2'd0,
        CFG_GAIN_I = 2'd1,
        CFG_GAIN_D = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DUTY_W-1:0] left;
        logic [DUTY_W-1:0] right;
    } t_duty_pair;

endpackage

`default_nettype wire

>>> rtl/edp_pid.sv
`default_nettype none

module edp_pid #(
    parameter int COUNT_WIDTH        = 16,
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  wire logic [COUNT_WIDTH-1:0]               i_count_a,
    input  wire logic [COUNT_WIDTH-1:0]               i_count_b,
    input  wire logic signed [edp_pkg::INTEGRAL_W-1:0] i_integral,
    input  wire logic signed [COUNT_WIDTH:0]          i_prev_err,
    input  wire logic [edp_pkg::GAIN_W-1:0]           i_gain_p,
    input  wire logic [edp_pkg::GAIN_W-1:0]           i_gain_i,
    input  wire logic [edp_pkg::GAIN_W-1:0]           i_gain_d,
    input  wire logic [edp_pkg::BASE_W-1:0]           i_base,
    output logic signed [edp_pkg::INTEGRAL_W-1:0]     o_integral,
    output logic signed [COUNT_WIDTH:0]               o_error,
    output edp_pkg::t_duty_pair                       o_duty
);
    import edp_pkg::*;

    localparam int ERR_W  = COUNT_WIDTH + 1;
    localparam int DER_W  = COUNT_WIDTH + 2;
    localparam int ISUM_W = ((INTEGRAL_W > ERR_W) ? INTEGRAL_W : ERR_W) + 1;
    localparam int SG_W   = GAIN_W + 1;
    localparam int P_W    = ERR_W + SG_W;
    localparam int I_W    = INTEGRAL_W + SG_W;
    localparam int D_W    = DER_W + SG_W;
    localparam int SUM_W  = ((I_W > D_W) ? I_W : D_W) + 2;
    localparam int CLP_W  = SUM_W + 1;

    localparam logic signed [ISUM_W-1:0] IMAX =
        ISUM_W'((64'sd1 <<< (INTEGRAL_W - 1)) - 64'sd1);
    localparam logic signed [ISUM_W-1:0] IMIN = -IMAX - ISUM_W'(1);
    localparam logic signed [SUM_W-1:0] RND =
        SUM_W'((64'sd1 <<< GAIN_FRACTION_BITS) - 64'sd1);
    localparam logic signed [CLP_W-1:0] CLP_MAX = CLP_W'(DUTY_MAX);

    logic signed [ERR_W-1:0]  err;
    logic signed [DER_W-1:0]  deriv;
    logic signed [ISUM_W-1:0] isum;
    logic signed [SG_W-1:0]   gp_s, gi_s, gd_s;
    logic signed [P_W-1:0]    prod_p;
    logic signed [I_W-1:0]    prod_i;
    logic signed [D_W-1:0]    prod_d;
    logic signed [SUM_W-1:0]  sum, bias, corr;
    logic signed [CLP_W-1:0]  base_s, left_v, right_v;

    // Error, derivative and saturated integral
    assign err   = $signed({1'b0, i_count_a}) - $signed({1'b0, i_count_b});
    assign deriv = DER_W'(err) - DER_W'(i_prev_err);
    assign isum  = ISUM_W'(i_integral) + ISUM_W'(err);

    always_comb begin
        if (isum > IMAX) begin
            o_integral = IMAX[INTEGRAL_W-1:0];
        end else if (isum < IMIN) begin
            o_integral = IMIN[INTEGRAL_W-1:0];
        end else begin
            o_integral = isum[INTEGRAL_W-1:0];
        end
    end

    assign o_error = err;

    // Gain-weighted terms, summed exactly
    assign gp_s   = $signed({1'b0, i_gain_p});
    assign gi_s   = $signed({1'b0, i_gain_i});
    assign gd_s   = $signed({1'b0, i_gain_d});
    assign prod_p = P_W'(gp_s) * P_W'(err);
    assign prod_i = I_W'(gi_s) * I_W'(o_integral);
    assign prod_d = D_W'(gd_s) * D_W'(deriv);
    assign sum    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

    // Drop fraction bits, rounding toward zero
    assign bias = sum[SUM_W-1] ? RND : '0;
    assign corr = (sum + bias) >>> GAIN_FRACTION_BITS;

    // Apply correction and clamp each duty to its range
    assign base_s  = CLP_W'($signed({1'b0, i_base}));
    assign left_v  = base_s - CLP_W'(corr);
    assign right_v = base_s + CLP_W'(corr);

    always_comb begin
        if (left_v[CLP_W-1]) begin
            o_duty.left = '0;
        end else if (left_v > CLP_MAX) begin
            o_duty.left = DUTY_MAX;
        end else begin
            o_duty.left = left_v[DUTY_W-1:0];
        end
        if (right_v[CLP_W-1]) begin
            o_duty.right = '0;
        end else if (right_v > CLP_MAX) begin
            o_duty.right = DUTY_MAX;
        end else begin
            o_duty.right = right_v[DUTY_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/encoder_sync_pid_drive_core.sv
// Path: an accepted item is held in the input register until the result register is free or drains.
// Throughput: one item per cycle while the output is not stalled; the PID step (three multipliers
//   into one adder and a clamp) is combinational between the input register and the result register.
// Reset (synchronous, active low): counts, integral, previous error, duties and direction
//   clear to zero, gains return to 591 / 0 / 243, and both pipeline stages empty.
`default_nettype none

module encoder_sync_pid_drive_core #(
    parameter int COUNT_WIDTH        = 16,
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input items
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [edp_pkg::CMD_W-1:0]       i_command,
    input  wire logic                            i_pulse_a,
    input  wire logic                            i_pulse_b,
    input  wire logic [edp_pkg::BASE_W-1:0]      i_base_speed,
    // Result items
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [edp_pkg::DUTY_W-1:0]           o_left_duty,
    output logic [edp_pkg::DUTY_W-1:0]           o_right_duty,
    output logic                                 o_reverse,
    output logic [edp_pkg::OUT_CNT_W-1:0]        o_count_a_out,
    output logic [edp_pkg::OUT_CNT_W-1:0]        o_count_b_out,
    // Configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [edp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [edp_pkg::GAIN_W-1:0]      i_cfg_data
);
    import edp_pkg::*;

    localparam int CNT_EXT_W = COUNT_WIDTH + OUT_CNT_W;

    // Gains
    logic [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;

    // Input stage
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic              r_s1_pulse_a, r_s1_pulse_b;
    logic [BASE_W-1:0] r_s1_base;

    // Controller state
    logic [COUNT_WIDTH-1:0]       r_count_a, r_count_b, n_count_a, n_count_b;
    logic signed [INTEGRAL_W-1:0] r_integral, n_integral;
    logic signed [COUNT_WIDTH:0]  r_prev_err, n_prev_err;
    t_duty_pair                   r_duty, n_duty;
    logic                         r_dir, n_dir;

    // Result stage
    logic                 r_out_valid;
    t_duty_pair           r_out_duty;
    logic                 r_out_dir;
    logic [OUT_CNT_W-1:0] r_out_cnt_a, r_out_cnt_b;

    logic                         in_acc, s1_move;
    logic signed [INTEGRAL_W-1:0] pid_integral;
    logic signed [COUNT_WIDTH:0]  pid_err;
    t_duty_pair                   pid_duty;
    logic [CNT_EXT_W-1:0]         ext_a, ext_b;

    // Handshake: the input stage advances whenever the result register is free or drains
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Write gains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= GAIN_P_RESET;
            r_gain_i <= GAIN_I_RESET;
            r_gain_d <= GAIN_D_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P: r_gain_p <= i_cfg_data;
                CFG_GAIN_I: r_gain_i <= i_cfg_data;
                CFG_GAIN_D: r_gain_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd     <= i_command;
            r_s1_pulse_a <= i_pulse_a;
            r_s1_pulse_b <= i_pulse_b;
            r_s1_base    <= i_base_speed;
        end
    end

    edp_pid #(
        .COUNT_WIDTH        (COUNT_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_pid (
        .i_count_a  (r_count_a),
        .i_count_b  (r_count_b),
        .i_integral (r_integral),
        .i_prev_err (r_prev_err),
        .i_gain_p   (r_gain_p),
        .i_gain_i   (r_gain_i),
        .i_gain_d   (r_gain_d),
        .i_base     (r_s1_base),
        .o_integral (pid_integral),
        .o_error    (pid_err),
        .o_duty     (pid_duty)
    );

    // Decode the command into the next controller state
    always_comb begin
        n_count_a  = r_count_a;
        n_count_b  = r_count_b;
        n_integral = r_integral;
        n_prev_err = r_prev_err;
        n_duty     = r_duty;
        n_dir      = r_dir;
        unique case (t_cmd'(r_s1_cmd)) inside
            CMD_PULSE: begin
                // Counts saturate at all ones
                if (r_s1_pulse_a && !(&r_count_a)) begin
                    n_count_a = r_count_a + COUNT_WIDTH'(1);
                end
                if (r_s1_pulse_b && !(&r_count_b)) begin
                    n_count_b = r_count_b + COUNT_WIDTH'(1);
                end
            end
            CMD_CLEAR: begin
                n_count_a = '0;
                n_count_b = '0;
            end
            CMD_FWD, CMD_BWD: begin
                n_integral = pid_integral;
                n_prev_err = pid_err;
                n_duty     = pid_duty;
                n_dir      = (t_cmd'(r_s1_cmd) == CMD_BWD);
            end
            CMD_STOP: begin
                n_duty = '0;
            end
            default: ;
        endcase
    end

    // Commit state as the item moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a  <= '0;
            r_count_b  <= '0;
            r_integral <= '0;
            r_prev_err <= '0;
            r_duty     <= '0;
            r_dir      <= 1'b0;
        end else if (s1_move) begin
            r_count_a  <= n_count_a;
            r_count_b  <= n_count_b;
            r_integral <= n_integral;
            r_prev_err <= n_prev_err;
            r_duty     <= n_duty;
            r_dir      <= n_dir;
        end
    end

    // Result register: load on advance, drop once taken
    assign ext_a = CNT_EXT_W'(n_count_a);
    assign ext_b = CNT_EXT_W'(n_count_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_duty  <= n_duty;
            r_out_dir   <= n_dir;
            r_out_cnt_a <= ext_a[OUT_CNT_W-1:0];
            r_out_cnt_b <= ext_b[OUT_CNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_duty   = r_out_duty.left;
    assign o_right_duty  = r_out_duty.right;
    assign o_reverse     = r_out_dir;
    assign o_count_a_out = r_out_cnt_a;
    assign o_count_b_out = r_out_cnt_b;

endmodule

`default_nettype wire

>>> rtl/edp_checker.sv
`default_nettype none

module edp_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire logic [edp_pkg::CMD_W-1:0]     i_command,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [edp_pkg::DUTY_W-1:0]    o_left_duty,
    input  wire logic [edp_pkg::DUTY_W-1:0]    o_right_duty,
    input  wire logic                          o_reverse,
    input  wire logic [edp_pkg::OUT_CNT_W-1:0] o_count_a_out,
    input  wire logic [edp_pkg::OUT_CNT_W-1:0] o_count_b_out
);
    import edp_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // A stalled item stays in place unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_left_duty)
            && $stable(o_right_duty) && $stable(o_reverse)
            && $stable(o_count_a_out) && $stable(o_count_b_out))
        else $error("stalled result changed or vanished");

    // A stop item reaches the output with both duties zero
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_command == CMD_STOP) ##1 !i_out_stall
            |=> o_out_valid && (o_left_duty == '0) && (o_right_duty == '0))
        else $error("stop did not zero the duties");

    // A backward update reports reverse direction
    a_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_command == CMD_BWD) ##1 !i_out_stall
            |=> o_out_valid && o_reverse)
        else $error("backward update did not set reverse");

    // A clear reports both counts at zero
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_command == CMD_CLEAR) ##1 !i_out_stall
            |=> o_out_valid && (o_count_a_out == '0) && (o_count_b_out == '0))
        else $error("clear did not zero the counts");

endmodule

bind encoder_sync_pid_drive_core edp_checker u_edp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_command     (i_command),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_left_duty   (o_left_duty),
    .o_right_duty  (o_right_duty),
    .o_reverse     (o_reverse),
    .o_count_a_out (o_count_a_out),
    .o_count_b_out (o_count_b_out)
);

`default_nettype wire

>>> bench/tb_encoder_sync_pid_drive_core.sv
`timescale 1ns / 1ps

module tb_encoder_sync_pid_drive_core;
    import edp_pkg::*;

    localparam int CNT_W     = 16;
    localparam int FRAC_BITS = 8;
    localparam int INTEG_MAX = (1 << (INTEGRAL_W - 1)) - 1;
    localparam int INTEG_MIN = -(1 << (INTEGRAL_W - 1));

    // Command and register codes that the package leaves undefined
    localparam logic [CMD_W-1:0]     CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              pulse_a;
        logic              pulse_b;
        logic [BASE_W-1:0] base_speed;
    } t_drive_item;

    typedef struct packed {
        logic [DUTY_W-1:0]    left;
        logic [DUTY_W-1:0]    right;
        logic                 reverse;
        logic [OUT_CNT_W-1:0] cnt_a;
        logic [OUT_CNT_W-1:0] cnt_b;
    } t_wheel_result;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid  = 1'b0;
    logic                   out_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [GAIN_W-1:0]      cfg_data  = '0;
    t_drive_item            cur_item  = '0;

    logic                   o_in_stall;
    logic                   o_out_valid;
    logic                   o_cfg_ready;
    logic [DUTY_W-1:0]      o_left_duty;
    logic [DUTY_W-1:0]      o_right_duty;
    logic                   o_reverse;
    logic [OUT_CNT_W-1:0]   o_count_a_out;
    logic [OUT_CNT_W-1:0]   o_count_b_out;

    // Stimulus and expectation stores
    t_drive_item   cmd_feed_q[$];
    t_wheel_result duty_expect_q[$];
    int            fail_count = 0;
    bit            quiet_mode = 1'b0;
    int            feed_gap   = 0;
    int            stall_left = 0;

    // Predictor state
    logic [GAIN_W-1:0]              kp, ki, kd;
    logic [CNT_W-1:0]               wheel_a, wheel_b;
    logic signed [INTEGRAL_W-1:0]   integ_acc;
    logic signed [CNT_W:0]          last_err;
    logic [DUTY_W-1:0]              duty_l, duty_r;
    logic                           reverse_q;

    encoder_sync_pid_drive_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (cur_item.command),
        .i_pulse_a    (cur_item.pulse_a),
        .i_pulse_b    (cur_item.pulse_b),
        .i_base_speed (cur_item.base_speed),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_left_duty  (o_left_duty),
        .o_right_duty (o_right_duty),
        .o_reverse    (o_reverse),
        .o_count_a_out(o_count_a_out),
        .o_count_b_out(o_count_b_out),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(DUTY_MAX))
            return DUTY_MAX;
        return v[DUTY_W-1:0];
    endfunction

    // Apply one item to the drive state and return the outputs after it
    function automatic t_wheel_result drive_step(t_drive_item it);
        longint        err, deriv, integ, acc, corr;
        t_wheel_result r;
        case (it.command)
            CMD_PULSE: begin
                if (it.pulse_a && wheel_a != '1)
                    wheel_a = wheel_a + CNT_W'(1);
                if (it.pulse_b && wheel_b != '1)
                    wheel_b = wheel_b + CNT_W'(1);
            end
            CMD_CLEAR: begin
                wheel_a = '0;
                wheel_b = '0;
            end
            CMD_FWD, CMD_BWD: begin
                err   = longint'(wheel_a) - longint'(wheel_b);
                deriv = err - longint'(last_err);
                integ = longint'(integ_acc) + err;
                if (integ > INTEG_MAX)
                    integ = INTEG_MAX;
                else if (integ < INTEG_MIN)
                    integ = INTEG_MIN;
                integ_acc = integ[INTEGRAL_W-1:0];
                acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * deriv;
                // Signed division truncates toward zero
                corr = acc / (longint'(1) << FRAC_BITS);
                duty_l    = clamp_duty(longint'(it.base_speed) - corr);
                duty_r    = clamp_duty(longint'(it.base_speed) + corr);
                last_err  = err[CNT_W:0];
                reverse_q = (it.command == CMD_BWD);
            end
            CMD_STOP: begin
                duty_l = '0;
                duty_r = '0;
            end
            default: ;
        endcase
        r.left    = duty_l;
        r.right   = duty_r;
        r.reverse = reverse_q;
        r.cnt_a   = wheel_a[OUT_CNT_W-1:0];
        r.cnt_b   = wheel_b[OUT_CNT_W-1:0];
        return r;
    endfunction

    // Driver: present queued items, predict each one as it is accepted
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            feed_gap  <= 0;
            kp        = GAIN_P_RESET;
            ki        = GAIN_I_RESET;
            kd        = GAIN_D_RESET;
            wheel_a   = '0;
            wheel_b   = '0;
            integ_acc = '0;
            last_err  = '0;
            duty_l    = '0;
            duty_r    = '0;
            reverse_q = 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                duty_expect_q.push_back(drive_step(cur_item));
            if (!in_valid || !o_in_stall) begin
                if (feed_gap != 0) begin
                    in_valid <= 1'b0;
                    feed_gap <= feed_gap - 1;
                end else if (cmd_feed_q.size() != 0) begin
                    cur_item <= cmd_feed_q.pop_front();
                    in_valid <= 1'b1;
                    feed_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: take results, compare against the oldest prediction
    always @(posedge i_clk) begin
        t_wheel_result want;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (duty_expect_q.size() == 0) begin
                    $error("result with no item pending");
                    fail_count++;
                end else begin
                    want = duty_expect_q.pop_front();
                    check_field("left_duty", want.left, o_left_duty);
                    check_field("right_duty", want.right, o_right_duty);
                    check_field("reverse", want.reverse, o_reverse);
                    check_field("count_a_out", want.cnt_a, o_count_a_out);
                    check_field("count_b_out", want.cnt_b, o_count_b_out);
                end
            end
            if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                out_stall  <= 1'b0;
                stall_left <= pick_gap();
            end
        end
    end

    task automatic push_item(logic [CMD_W-1:0] c, logic a, logic b, logic [BASE_W-1:0] base);
        t_drive_item it;
        it.command    = c;
        it.pulse_a    = a;
        it.pulse_b    = b;
        it.base_speed = base;
        cmd_feed_q.push_back(it);
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return BASE_W'($urandom_range(0, 255));
    endfunction

    // Hold until every queued item is in and every result is out
    task automatic wait_idle();
        while (cmd_feed_q.size() != 0 || in_valid || duty_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_GAIN_P: kp = val;
            CFG_GAIN_I: ki = val;
            CFG_GAIN_D: kd = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Write all three gains; sometimes poke the unused index too
    task automatic set_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                             logic [GAIN_W-1:0] d);
        wait_idle();
        write_gain(CFG_GAIN_P, p);
        write_gain(CFG_GAIN_I, i);
        if ($urandom_range(0, 1) == 1)
            write_gain(CFG_SPARE, GAIN_W'($urandom_range(0, 65535)));
        write_gain(CFG_GAIN_D, d);
    endtask

    // Pulse bursts closed by an update, mixed with clears, stops and noise
    task automatic queue_random_phase(int n);
        int count, r, k, pa_pct, pb_pct;
        count = 0;
        while (count < n) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                k      = $urandom_range(1, 12);
                pa_pct = $urandom_range(0, 100);
                pb_pct = $urandom_range(0, 100);
                repeat (k)
                    push_item(CMD_PULSE, $urandom_range(0, 99) < pa_pct,
                              $urandom_range(0, 99) < pb_pct,
                              BASE_W'($urandom_range(0, 255)));
                push_item($urandom_range(0, 1) ? CMD_BWD : CMD_FWD,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_base());
                count += k + 1;
            end else begin
                if (r < 83)
                    push_item(CMD_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              BASE_W'($urandom_range(0, 255)));
                else if (r < 90)
                    push_item(CMD_STOP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              BASE_W'($urandom_range(0, 255)));
                else if (r < 95)
                    push_item(CMD_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              BASE_W'($urandom_range(0, 255)));
                else
                    push_item(CMD_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), BASE_W'($urandom_range(0, 255)));
                count++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: reset gains, field extremes, every command, ignored fields
        push_item(CMD_FWD, 1'b0, 1'b0, 8'd0);
        push_item(CMD_BWD, 1'b1, 1'b1, 8'd255);
        push_item(CMD_PULSE, 1'b1, 1'b0, 8'd255);
        push_item(CMD_PULSE, 1'b1, 1'b1, 8'd0);
        push_item(CMD_PULSE, 1'b0, 1'b1, 8'd170);
        push_item(CMD_PULSE, 1'b0, 1'b0, 8'd85);
        push_item(CMD_PULSE, 1'b1, 1'b0, 8'd0);
        push_item(CMD_PULSE, 1'b1, 1'b0, 8'd0);
        push_item(CMD_FWD, 1'b1, 1'b1, 8'd128);
        push_item(CMD_BWD, 1'b0, 1'b0, 8'd200);
        push_item(CMD_STOP, 1'b1, 1'b1, 8'd255);
        push_item(CMD_SPARE_5, 1'b1, 1'b1, 8'd255);
        push_item(CMD_SPARE_6, 1'b1, 1'b0, 8'd0);
        push_item(CMD_SPARE_7, 1'b0, 1'b1, 8'd77);
        push_item(CMD_FWD, 1'b0, 1'b0, 8'd255);
        push_item(CMD_CLEAR, 1'b1, 1'b1, 8'd255);
        push_item(CMD_FWD, 1'b0, 1'b0, 8'd255);
        repeat (4)
            push_item(CMD_PULSE, 1'b0, 1'b1, 8'd0);
        push_item(CMD_BWD, 1'b0, 1'b0, 8'd0);
        push_item(CMD_FWD, 1'b0, 1'b0, 8'd90);
        push_item(CMD_STOP, 1'b0, 1'b0, 8'd0);

        // Random phases over several gain settings, reset gains first
        queue_random_phase(150);
        set_gains('1, '1, '1);
        queue_random_phase(150);
        set_gains('0, '0, '0);
        queue_random_phase(120);
        quiet_mode = 1'b1;
        set_gains(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
                  GAIN_W'($urandom_range(0, 65535)));
        queue_random_phase(120);
        wait_idle();
        quiet_mode = 1'b0;
        set_gains(GAIN_W'($urandom_range(0, 1023)), GAIN_W'($urandom_range(0, 1023)),
                  GAIN_W'($urandom_range(0, 1023)));
        queue_random_phase(150);
        set_gains(16'd256, '1, '0);
        queue_random_phase(150);

        // Back to the reset gains for a last phase
        set_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
        queue_random_phase(60);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Give up after a generous bound
    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
